@@ sv/ata_pio_read_sequencer_macros.svh @@
// assertion macros for the ata pio read sequencer checker
// both expect clk and arst_n in scope
`ifndef ATA_PIO_READ_SEQUENCER_MACROS_SVH
`define ATA_PIO_READ_SEQUENCER_MACROS_SVH

// same-cycle implication, disabled in reset
`define APRS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define APRS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/aprs_pkg.sv @@
// ----------------------------------------------------------------------------
// aprs_pkg
// types, codes and constants shared by the ata pio read sequencer modules
// ----------------------------------------------------------------------------
package aprs_pkg;

	localparam int unsigned LBA_W       = 28;
	localparam int unsigned COUNT_W     = 29;
	localparam int unsigned IDX_W       = 36;
	localparam int unsigned WORD_W      = 16;
	localparam int unsigned POLL_W      = 17;
	localparam int unsigned BATCH_W     = 8;
	localparam int unsigned MAX_BATCH   = 255;
	localparam int unsigned WORDS_PER_SECTOR = 256;
	localparam int unsigned POLL_LIMIT_RESET = 100000;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

	// task file register offsets
	localparam logic [2:0] REG_NONE    = 3'd0;
	localparam logic [2:0] REG_COUNT   = 3'd2;
	localparam logic [2:0] REG_LBA_LO  = 3'd3;
	localparam logic [2:0] REG_LBA_MID = 3'd4;
	localparam logic [2:0] REG_LBA_HI  = 3'd5;
	localparam logic [2:0] REG_DRIVE   = 3'd6;
	localparam logic [2:0] REG_COMMAND = 3'd7;

	localparam logic [7:0] DRIVE_LBA_BASE   = 8'hE0;
	localparam logic [7:0] CMD_READ_SECTORS = 8'h20;

	// status bits
	localparam int unsigned ST_BSY = 7;
	localparam int unsigned ST_DRQ = 3;
	localparam int unsigned ST_ERR = 0;

	// setup sequence: six task file writes then a status request
	localparam logic [2:0] SETUP_LAST_STEP = 3'd6;

	typedef enum logic [0:0] {
		CFG_DRIVE_PRESENT = 1'b0,
		CFG_POLL_LIMIT    = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MODE_START  = 2'd0,
		MODE_STATUS = 2'd1,
		MODE_DATA   = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		PH_IDLE     = 2'd0,
		PH_WAIT_BSY = 2'd1,
		PH_WAIT_DRQ = 2'd2,
		PH_DATA     = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		RK_REG_WRITE  = 3'd0,
		RK_STATUS_REQ = 3'd1,
		RK_BURST_REQ  = 3'd2,
		RK_WORD       = 3'd3,
		RK_DONE_OK    = 3'd4,
		RK_DONE_ERR   = 3'd5
	} rkind_t;

	typedef enum logic [1:0] {
		JOB_ONE   = 2'd0,
		JOB_WORD  = 2'd1,
		JOB_SETUP = 2'd2
	} job_op_t;

	// one classified item, expanded into beats by the back end
	typedef struct packed {
		job_op_t              op;
		rkind_t               kind;    // single beat kind, or the beat after a word
		logic                 follow;  // word job has a trailing beat
		logic [LBA_W-1:0]     lba;
		logic [BATCH_W-1:0]   batch;
		logic [IDX_W-1:0]     idx;
		logic [WORD_W-1:0]    data;
	} job_t;

	typedef struct packed {
		rkind_t               kind;
		logic [2:0]           sel;
		logic [7:0]           value;
		logic [IDX_W-1:0]     idx;
		logic [WORD_W-1:0]    data;
		logic                 last;
	} rsp_t;

	typedef struct packed {
		logic push;
		logic pop;
	} q_ctl_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

@@ sv/aprs_queue.sv @@
// ----------------------------------------------------------------------------
// aprs_queue
// short job queue between the classifying front end and the beat back end
// ----------------------------------------------------------------------------
module aprs_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  aprs_pkg::q_ctl_t   ctl,
	input  aprs_pkg::job_t     wr_job,
	output aprs_pkg::job_t     rd_job,
	output aprs_pkg::q_stat_t  stat
);

	aprs_pkg::job_t                    mem_q [aprs_pkg::QUEUE_DEPTH];
	logic [aprs_pkg::QUEUE_AW-1:0]     wr_ptr_q;
	logic [aprs_pkg::QUEUE_AW-1:0]     rd_ptr_q;
	logic [aprs_pkg::QUEUE_AW:0]       count_q;
	logic                              do_push;
	logic                              do_pop;

	assign stat.full  = (count_q == (aprs_pkg::QUEUE_AW+1)'(aprs_pkg::QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push    = ctl.push && !stat.full;
	assign do_pop     = ctl.pop && !stat.empty;
	assign rd_job     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ sv/aprs_front.sv @@
// ----------------------------------------------------------------------------
// aprs_front
// accepts input items, runs the request state and pushes at most one job per item
// ----------------------------------------------------------------------------
module aprs_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  aprs_pkg::cfg_reg_t                  cfg_index,
	input  logic [aprs_pkg::POLL_W-1:0]         cfg_data,
	input  logic                                accept,
	input  logic [1:0]                          mode,
	input  logic [aprs_pkg::LBA_W-1:0]          start_lba,
	input  logic [aprs_pkg::COUNT_W-1:0]        sector_count,
	input  logic [7:0]                          status_byte,
	input  logic [aprs_pkg::WORD_W-1:0]         data_in,
	output logic                                push,
	output aprs_pkg::job_t                      job
);

	logic                              drive_present_q;
	logic [aprs_pkg::POLL_W-1:0]       poll_limit_q;

	aprs_pkg::phase_t                  phase_q, phase_n;
	logic [aprs_pkg::LBA_W-1:0]        lba_q, lba_n;
	logic [aprs_pkg::COUNT_W-1:0]      sectors_q, sectors_n;
	logic [aprs_pkg::BATCH_W-1:0]      batch_q, batch_n;
	logic [7:0]                        word_cnt_q, word_cnt_n;
	logic [aprs_pkg::POLL_W-1:0]       poll_q, poll_n;
	logic [aprs_pkg::IDX_W-1:0]        offset_q, offset_n;

	logic [aprs_pkg::POLL_W-1:0]       poll_inc;
	logic                              poll_timeout;
	logic [aprs_pkg::BATCH_W-1:0]      batch_size;
	logic [aprs_pkg::BATCH_W-1:0]      batch_dec;
	logic [aprs_pkg::COUNT_W-1:0]      sectors_dec;

	assign poll_inc     = poll_q + 1'b1;
	assign poll_timeout = (poll_inc >= poll_limit_q);
	assign batch_size   = (sectors_q > aprs_pkg::COUNT_W'(aprs_pkg::MAX_BATCH)) ?
		aprs_pkg::BATCH_W'(aprs_pkg::MAX_BATCH) : sectors_q[aprs_pkg::BATCH_W-1:0];
	assign batch_dec    = batch_q - 1'b1;
	assign sectors_dec  = sectors_q - 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_present_q <= 1'b0;
			poll_limit_q    <= aprs_pkg::POLL_W'(aprs_pkg::POLL_LIMIT_RESET);
		end else if (cfg_valid) begin
			case (cfg_index)
				aprs_pkg::CFG_DRIVE_PRESENT: drive_present_q <= cfg_data[0];
				aprs_pkg::CFG_POLL_LIMIT:    poll_limit_q    <= cfg_data;
				default:                     poll_limit_q    <= poll_limit_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= aprs_pkg::PH_IDLE;
			lba_q      <= '0;
			sectors_q  <= '0;
			batch_q    <= '0;
			word_cnt_q <= '0;
			poll_q     <= '0;
			offset_q   <= '0;
		end else begin
			phase_q    <= phase_n;
			lba_q      <= lba_n;
			sectors_q  <= sectors_n;
			batch_q    <= batch_n;
			word_cnt_q <= word_cnt_n;
			poll_q     <= poll_n;
			offset_q   <= offset_n;
		end
	end

	always_comb begin
		phase_n    = phase_q;
		lba_n      = lba_q;
		sectors_n  = sectors_q;
		batch_n    = batch_q;
		word_cnt_n = word_cnt_q;
		poll_n     = poll_q;
		offset_n   = offset_q;
		push       = 1'b0;
		job        = '0;
		job.op     = aprs_pkg::JOB_ONE;
		job.kind   = aprs_pkg::RK_STATUS_REQ;

		if (accept) begin
			case (mode)
				aprs_pkg::MODE_START: begin
					// a start always abandons whatever was running
					phase_n = aprs_pkg::PH_IDLE;
					push    = 1'b1;
					if (!drive_present_q) begin
						job.kind = aprs_pkg::RK_DONE_ERR;
					end else if (sector_count == '0) begin
						job.kind = aprs_pkg::RK_DONE_OK;
					end else begin
						lba_n      = start_lba;
						sectors_n  = sector_count;
						batch_n    = '0;
						word_cnt_n = '0;
						offset_n   = '0;
						poll_n     = '0;
						phase_n    = aprs_pkg::PH_WAIT_BSY;
					end
				end
				aprs_pkg::MODE_STATUS: begin
					if (phase_q == aprs_pkg::PH_WAIT_BSY) begin
						push = 1'b1;
						if (!status_byte[aprs_pkg::ST_BSY]) begin
							job.op    = aprs_pkg::JOB_SETUP;
							job.lba   = lba_q;
							job.batch = batch_size;
							batch_n   = batch_size;
							poll_n    = '0;
							phase_n   = aprs_pkg::PH_WAIT_DRQ;
						end else begin
							poll_n = poll_inc;
							if (poll_timeout) begin
								phase_n  = aprs_pkg::PH_IDLE;
								job.kind = aprs_pkg::RK_DONE_ERR;
							end
						end
					end else if (phase_q == aprs_pkg::PH_WAIT_DRQ) begin
						push = 1'b1;
						// err wins over drq, bsy is ignored here
						if (status_byte[aprs_pkg::ST_ERR]) begin
							phase_n  = aprs_pkg::PH_IDLE;
							job.kind = aprs_pkg::RK_DONE_ERR;
						end else if (status_byte[aprs_pkg::ST_DRQ]) begin
							word_cnt_n = '0;
							phase_n    = aprs_pkg::PH_DATA;
							job.kind   = aprs_pkg::RK_BURST_REQ;
						end else begin
							poll_n = poll_inc;
							if (poll_timeout) begin
								phase_n  = aprs_pkg::PH_IDLE;
								job.kind = aprs_pkg::RK_DONE_ERR;
							end
						end
					end
				end
				aprs_pkg::MODE_DATA: begin
					if (phase_q == aprs_pkg::PH_DATA) begin
						push     = 1'b1;
						job.op   = aprs_pkg::JOB_WORD;
						job.idx  = offset_q;
						job.data = data_in;
						offset_n = offset_q + 1'b1;
						if (word_cnt_q == 8'(aprs_pkg::WORDS_PER_SECTOR - 1)) begin
							word_cnt_n = '0;
							batch_n    = batch_dec;
							sectors_n  = sectors_dec;
							lba_n      = lba_q + 1'b1;
							poll_n     = '0;
							job.follow = 1'b1;
							if (batch_dec != '0) begin
								phase_n = aprs_pkg::PH_WAIT_DRQ;
							end else if (sectors_dec != '0) begin
								phase_n = aprs_pkg::PH_WAIT_BSY;
							end else begin
								phase_n  = aprs_pkg::PH_IDLE;
								job.kind = aprs_pkg::RK_DONE_OK;
							end
						end else begin
							word_cnt_n = word_cnt_q + 1'b1;
						end
					end
				end
				default: begin
					push = 1'b0;
				end
			endcase
		end
	end

endmodule

@@ sv/aprs_back.sv @@
// ----------------------------------------------------------------------------
// aprs_back
// expands queued jobs into result beats behind an output register
// ----------------------------------------------------------------------------
module aprs_back (
	input  logic               clk,
	input  logic               arst_n,
	input  aprs_pkg::job_t     job,
	input  logic               job_valid,
	output logic               pop,
	input  logic               rsp_stall,
	output logic               rsp_valid,
	output aprs_pkg::rsp_t     rsp
);

	logic [2:0]        step_q;
	logic              out_valid_q;
	aprs_pkg::rsp_t    out_q;
	aprs_pkg::rsp_t    beat;
	logic              final_beat;
	logic              load;
	logic              take;

	always_comb begin
		beat       = '0;
		final_beat = 1'b1;
		beat.kind  = job.kind;
		case (job.op)
			aprs_pkg::JOB_ONE: begin
				final_beat = 1'b1;
			end
			aprs_pkg::JOB_WORD: begin
				if (step_q == '0) begin
					beat.kind  = aprs_pkg::RK_WORD;
					beat.idx   = job.idx;
					beat.data  = job.data;
					final_beat = !job.follow;
				end
			end
			aprs_pkg::JOB_SETUP: begin
				final_beat = (step_q == aprs_pkg::SETUP_LAST_STEP);
				if (!final_beat) begin
					beat.kind = aprs_pkg::RK_REG_WRITE;
				end
				case (step_q)
					3'd0: begin
						beat.sel   = aprs_pkg::REG_DRIVE;
						beat.value = aprs_pkg::DRIVE_LBA_BASE | {4'b0, job.lba[27:24]};
					end
					3'd1: begin
						beat.sel   = aprs_pkg::REG_COUNT;
						beat.value = job.batch;
					end
					3'd2: begin
						beat.sel   = aprs_pkg::REG_LBA_LO;
						beat.value = job.lba[7:0];
					end
					3'd3: begin
						beat.sel   = aprs_pkg::REG_LBA_MID;
						beat.value = job.lba[15:8];
					end
					3'd4: begin
						beat.sel   = aprs_pkg::REG_LBA_HI;
						beat.value = job.lba[23:16];
					end
					3'd5: begin
						beat.sel   = aprs_pkg::REG_COMMAND;
						beat.value = aprs_pkg::CMD_READ_SECTORS;
					end
					default: begin
						beat.sel   = aprs_pkg::REG_NONE;
					end
				endcase
			end
			default: begin
				final_beat = 1'b1;
			end
		endcase
		beat.last = final_beat;
	end

	assign load      = !out_valid_q || !rsp_stall;
	assign take      = load && job_valid;
	assign pop       = take && final_beat;
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= beat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			step_q      <= '0;
		end else begin
			if (load) begin
				out_valid_q <= job_valid;
			end
			if (take) begin
				step_q <= final_beat ? 3'd0 : step_q + 1'b1;
			end
		end
	end

endmodule

@@ sv/ata_pio_read_sequencer.sv @@
// ----------------------------------------------------------------------------
// ata_pio_read_sequencer
// host side ata pio read sequencer for 28-bit lba
// ----------------------------------------------------------------------------
// req channel (req_valid/req_stall) takes one item per beat: a start (mode 0,
// start_lba, sector_count), a sampled status byte (mode 1) or a data word
// (mode 2). rsp channel (rsp_valid/rsp_stall) returns the results: task file
// writes, status and burst requests, buffer words and done codes; last marks
// the final result of each input item. cfg channel writes drive_present
// (index 0) and poll_limit (index 1) and is always ready; write it only while
// the block is idle.
// the front end takes an item every cycle while its four-entry job queue has
// room; the first result of an item passes the job queue and then the output
// register before it shows on rsp. the back end drives one result beat per
// cycle while rsp_stall is low; a batch setup gives six register writes plus
// a status request. when rsp_stall is high the output register holds, the
// queue fills and then req_stall rises. reset returns to idle with an empty
// queue, drive_present 0 and poll_limit 100000.
// ----------------------------------------------------------------------------
module ata_pio_read_sequencer (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [0:0]                          cfg_index,
	input  logic [aprs_pkg::POLL_W-1:0]         cfg_data,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  logic [1:0]                          mode,
	input  logic [aprs_pkg::LBA_W-1:0]          start_lba,
	input  logic [aprs_pkg::COUNT_W-1:0]        sector_count,
	input  logic [7:0]                          status_byte,
	input  logic [aprs_pkg::WORD_W-1:0]         data_in,
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output logic [2:0]                          kind,
	output logic [2:0]                          reg_select,
	output logic [7:0]                          reg_value,
	output logic [aprs_pkg::IDX_W-1:0]          buffer_index,
	output logic [aprs_pkg::WORD_W-1:0]         data_out,
	output logic                                last
);

	aprs_pkg::q_ctl_t   q_ctl;
	aprs_pkg::q_stat_t  q_stat;
	aprs_pkg::job_t     push_job;
	aprs_pkg::job_t     head_job;
	aprs_pkg::rsp_t     rsp;
	logic               accept;

	assign cfg_ready = 1'b1;
	assign req_stall = q_stat.full;
	assign accept    = req_valid && !req_stall;

	aprs_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid && cfg_ready),
		.cfg_index    (aprs_pkg::cfg_reg_t'(cfg_index)),
		.cfg_data     (cfg_data),
		.accept       (accept),
		.mode         (mode),
		.start_lba    (start_lba),
		.sector_count (sector_count),
		.status_byte  (status_byte),
		.data_in      (data_in),
		.push         (q_ctl.push),
		.job          (push_job)
	);

	aprs_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (q_ctl),
		.wr_job (push_job),
		.rd_job (head_job),
		.stat   (q_stat)
	);

	aprs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (head_job),
		.job_valid (!q_stat.empty),
		.pop       (q_ctl.pop),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

	assign kind         = rsp.kind;
	assign reg_select   = rsp.sel;
	assign reg_value    = rsp.value;
	assign buffer_index = rsp.idx;
	assign data_out     = rsp.data;
	assign last         = rsp.last;

endmodule

@@ sv/aprs_checker.sv @@
// ----------------------------------------------------------------------------
// aprs_checker
// port-level checks on the ata pio read sequencer, bound to the top level
// ----------------------------------------------------------------------------
`include "ata_pio_read_sequencer_macros.svh"

module aprs_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                rsp_valid,
	input  logic                                rsp_stall,
	input  logic [2:0]                          kind,
	input  logic [2:0]                          reg_select,
	input  logic [7:0]                          reg_value,
	input  logic [aprs_pkg::IDX_W-1:0]          buffer_index,
	input  logic [aprs_pkg::WORD_W-1:0]         data_out,
	input  logic                                last
);

	// a stalled beat stays valid and keeps its kind, buffer index and last flag
	`APRS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
		rsp_valid && $stable(kind) && $stable(buffer_index) && $stable(last),
		"rsp beat changed while stalled")

	// done codes always end the results of their item
	`APRS_ASSERT_NOW(a_done_last,
		rsp_valid && (kind == aprs_pkg::RK_DONE_OK || kind == aprs_pkg::RK_DONE_ERR),
		last, "done beat without last")

	// task file fields only on register writes
	`APRS_ASSERT_NOW(a_reg_fields, rsp_valid && kind != aprs_pkg::RK_REG_WRITE,
		reg_select == '0 && reg_value == '0, "register fields set on non-write beat")

	// buffer fields only on buffer words
	`APRS_ASSERT_NOW(a_word_fields, rsp_valid && kind != aprs_pkg::RK_WORD,
		buffer_index == '0 && data_out == '0, "buffer fields set on non-word beat")

	// a register write is never the final result of an item
	`APRS_ASSERT_NOW(a_write_not_last, rsp_valid && kind == aprs_pkg::RK_REG_WRITE,
		!last, "register write marked last")

endmodule

bind ata_pio_read_sequencer aprs_checker u_aprs_checker (.*);

@@ tb/ata_pio_read_sequencer_test.sv @@
// ----------------------------------------------------------------------------
// ata_pio_read_sequencer_test
// self-checking bench for the ata pio read sequencer: a short directed script,
// then random read sessions under several register settings and flow control
// mixes; every result beat is checked against an in-bench copy of the block
// ----------------------------------------------------------------------------
module ata_pio_read_sequencer_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int DRAIN_CYCLES = 64;

	typedef struct packed {
		logic                            is_cfg;
		aprs_pkg::cfg_reg_t              cfg_id;
		logic [aprs_pkg::POLL_W-1:0]     cfg_val;
		logic [1:0]                      m;
		logic [aprs_pkg::LBA_W-1:0]      lba;
		logic [aprs_pkg::COUNT_W-1:0]    cnt;
		logic [7:0]                      st;
		logic [aprs_pkg::WORD_W-1:0]     w;
		logic                            typed;
		aprs_pkg::rkind_t                want;
	} plan_row_t;

	logic                            clk;
	logic                            arst_n = 1'b0;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [0:0]                      cfg_index = '0;
	logic [aprs_pkg::POLL_W-1:0]     cfg_data = '0;
	logic                            req_valid = 1'b0;
	logic                            req_stall;
	logic [1:0]                      mode = '0;
	logic [aprs_pkg::LBA_W-1:0]      start_lba = '0;
	logic [aprs_pkg::COUNT_W-1:0]    sector_count = '0;
	logic [7:0]                      status_byte = '0;
	logic [aprs_pkg::WORD_W-1:0]     data_in = '0;
	logic                            rsp_valid;
	logic                            rsp_stall = 1'b0;
	logic [2:0]                      kind;
	logic [2:0]                      reg_select;
	logic [7:0]                      reg_value;
	logic [aprs_pkg::IDX_W-1:0]      buffer_index;
	logic [aprs_pkg::WORD_W-1:0]     data_out;
	logic                            last;

	// sequencer state as the bench sees it
	aprs_pkg::phase_t                ph = aprs_pkg::PH_IDLE;
	logic [aprs_pkg::LBA_W-1:0]      lba_now = '0;
	logic [aprs_pkg::COUNT_W-1:0]    sec_left = '0;
	logic [aprs_pkg::BATCH_W-1:0]    batch_left = '0;
	logic [7:0]                      word_cnt = '0;
	logic [aprs_pkg::POLL_W-1:0]     polls = '0;
	logic [aprs_pkg::IDX_W-1:0]      word_off = '0;
	logic                            drv_on = 1'b0;
	logic [aprs_pkg::POLL_W-1:0]     poll_lim = aprs_pkg::POLL_W'(aprs_pkg::POLL_LIMIT_RESET);

	aprs_pkg::rsp_t                  host_ops_due[$];
	int                              faults = 0;
	int                              useful_items = 0;
	int                              idle_pct = 0;
	int                              stall_pct = 0;
	int                              hold_ask = 0;
	int                              hold_left = 0;
	bit                              long_read_done = 1'b0;

	ata_pio_read_sequencer dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.mode(mode),
		.start_lba(start_lba),
		.sector_count(sector_count),
		.status_byte(status_byte),
		.data_in(data_in),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.kind(kind),
		.reg_select(reg_select),
		.reg_value(reg_value),
		.buffer_index(buffer_index),
		.data_out(data_out),
		.last(last)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("ata_pio_read_sequencer test failed");
		$finish;
	end

	function automatic void due(aprs_pkg::rkind_t k, logic [2:0] sel = aprs_pkg::REG_NONE,
			logic [7:0] val = '0, logic [aprs_pkg::IDX_W-1:0] idx = '0,
			logic [aprs_pkg::WORD_W-1:0] d = '0);
		host_ops_due.push_back('{kind: k, sel: sel, value: val, idx: idx, data: d, last: 1'b0});
	endfunction

	// one more failed status poll; true once the wait has used up its polls
	function automatic bit poll_spent();
		polls = polls + 1'b1;
		return polls >= poll_lim;
	endfunction

	task automatic advance_sequencer(logic [1:0] m, logic [aprs_pkg::LBA_W-1:0] lba,
			logic [aprs_pkg::COUNT_W-1:0] cnt, logic [7:0] st,
			logic [aprs_pkg::WORD_W-1:0] w, bit typed, aprs_pkg::rkind_t want);
		int base;
		logic [aprs_pkg::BATCH_W-1:0] batch;
		base = host_ops_due.size();
		if (m == aprs_pkg::MODE_START) begin
			ph = aprs_pkg::PH_IDLE;
			if (!drv_on) begin
				due(aprs_pkg::RK_DONE_ERR);
			end else if (cnt == '0) begin
				due(aprs_pkg::RK_DONE_OK);
			end else begin
				lba_now = lba;
				sec_left = cnt;
				batch_left = '0;
				word_cnt = '0;
				word_off = '0;
				polls = '0;
				ph = aprs_pkg::PH_WAIT_BSY;
				due(aprs_pkg::RK_STATUS_REQ);
			end
		end else if (m == aprs_pkg::MODE_STATUS && ph == aprs_pkg::PH_WAIT_BSY) begin
			if (!st[aprs_pkg::ST_BSY]) begin
				batch = (sec_left > aprs_pkg::MAX_BATCH) ?
					aprs_pkg::BATCH_W'(aprs_pkg::MAX_BATCH) : sec_left[aprs_pkg::BATCH_W-1:0];
				due(aprs_pkg::RK_REG_WRITE, aprs_pkg::REG_DRIVE,
					aprs_pkg::DRIVE_LBA_BASE | {4'h0, lba_now[27:24]});
				due(aprs_pkg::RK_REG_WRITE, aprs_pkg::REG_COUNT, batch);
				due(aprs_pkg::RK_REG_WRITE, aprs_pkg::REG_LBA_LO, lba_now[7:0]);
				due(aprs_pkg::RK_REG_WRITE, aprs_pkg::REG_LBA_MID, lba_now[15:8]);
				due(aprs_pkg::RK_REG_WRITE, aprs_pkg::REG_LBA_HI, lba_now[23:16]);
				due(aprs_pkg::RK_REG_WRITE, aprs_pkg::REG_COMMAND, aprs_pkg::CMD_READ_SECTORS);
				due(aprs_pkg::RK_STATUS_REQ);
				batch_left = batch;
				polls = '0;
				ph = aprs_pkg::PH_WAIT_DRQ;
			end else if (poll_spent()) begin
				ph = aprs_pkg::PH_IDLE;
				due(aprs_pkg::RK_DONE_ERR);
			end else begin
				due(aprs_pkg::RK_STATUS_REQ);
			end
		end else if (m == aprs_pkg::MODE_STATUS && ph == aprs_pkg::PH_WAIT_DRQ) begin
			// error wins over drq, busy is ignored here
			if (st[aprs_pkg::ST_ERR]) begin
				ph = aprs_pkg::PH_IDLE;
				due(aprs_pkg::RK_DONE_ERR);
			end else if (st[aprs_pkg::ST_DRQ]) begin
				word_cnt = '0;
				ph = aprs_pkg::PH_DATA;
				due(aprs_pkg::RK_BURST_REQ);
			end else if (poll_spent()) begin
				ph = aprs_pkg::PH_IDLE;
				due(aprs_pkg::RK_DONE_ERR);
			end else begin
				due(aprs_pkg::RK_STATUS_REQ);
			end
		end else if (m == aprs_pkg::MODE_DATA && ph == aprs_pkg::PH_DATA) begin
			due(aprs_pkg::RK_WORD, aprs_pkg::REG_NONE, '0, word_off, w);
			word_off = word_off + 1'b1;
			if (word_cnt == 8'(aprs_pkg::WORDS_PER_SECTOR - 1)) begin
				word_cnt = '0;
				batch_left = batch_left - 1'b1;
				sec_left = sec_left - 1'b1;
				lba_now = lba_now + 1'b1;
				polls = '0;
				if (batch_left != '0) begin
					ph = aprs_pkg::PH_WAIT_DRQ;
					due(aprs_pkg::RK_STATUS_REQ);
				end else if (sec_left != '0) begin
					ph = aprs_pkg::PH_WAIT_BSY;
					due(aprs_pkg::RK_STATUS_REQ);
				end else begin
					ph = aprs_pkg::PH_IDLE;
					due(aprs_pkg::RK_DONE_OK);
				end
			end else begin
				word_cnt = word_cnt + 1'b1;
			end
		end
		if (typed) begin
			while (host_ops_due.size() > base)
				void'(host_ops_due.pop_back());
			due(want);
		end
		if (host_ops_due.size() > base) begin
			host_ops_due[host_ops_due.size() - 1].last = 1'b1;
			useful_items++;
		end
	endtask

	// offer one beat on req, update the bench state once it is taken
	task automatic send(logic [1:0] m, logic [aprs_pkg::LBA_W-1:0] lba,
			logic [aprs_pkg::COUNT_W-1:0] cnt, logic [7:0] st,
			logic [aprs_pkg::WORD_W-1:0] w, bit typed = 1'b0,
			aprs_pkg::rkind_t want = aprs_pkg::RK_DONE_OK);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		mode <= m;
		start_lba <= lba;
		sector_count <= cnt;
		status_byte <= st;
		data_in <= w;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		advance_sequencer(m, lba, cnt, st, w, typed, want);
	endtask

	task automatic drain();
		@(negedge clk);
		req_valid <= 1'b0;
		while (host_ops_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_setting(aprs_pkg::cfg_reg_t id, logic [aprs_pkg::POLL_W-1:0] val);
		@(negedge clk);
		cfg_index <= id;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		if (id == aprs_pkg::CFG_DRIVE_PRESENT)
			drv_on = val[0];
		else
			poll_lim = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// one request from its start, run to its end or cut short in a data burst, with some noise mixed in
	task automatic read_session();
		bit whole;
		int cut;
		int words;
		int r;
		logic [aprs_pkg::LBA_W-1:0] lba;
		logic [aprs_pkg::COUNT_W-1:0] cnt;
		logic [7:0] st;
		// only the first session reads a whole sector, the rest are cut short
		whole = !long_read_done;
		long_read_done = 1'b1;
		cut = $urandom_range(1, 24);
		words = 0;
		r = $urandom_range(99);
		if (r < 10)
			lba = '0;
		else if (r < 25)
			lba = aprs_pkg::LBA_W'(28'hFFF_FFFF - $urandom_range(0, 1));
		else
			lba = aprs_pkg::LBA_W'($urandom);
		r = $urandom_range(99);
		if (whole)
			cnt = aprs_pkg::COUNT_W'(1);
		else if (r < 10)
			cnt = '0;
		else if (r < 20)
			cnt = '1;
		else if (r < 35)
			cnt = {1'b1, aprs_pkg::LBA_W'($urandom)};
		else if (r < 70)
			cnt = aprs_pkg::COUNT_W'($urandom_range(1, 600));
		else
			cnt = aprs_pkg::COUNT_W'($urandom);
		send(aprs_pkg::MODE_START, lba, cnt, 8'($urandom), 16'($urandom));
		while (ph != aprs_pkg::PH_IDLE) begin
			st = 8'($urandom);
			r = $urandom_range(99);
			if (r < 3) begin
				// out-of-turn or unused mode beats, all ignored
				if (r == 0)
					send(MODE_UNUSED, aprs_pkg::LBA_W'($urandom),
						aprs_pkg::COUNT_W'($urandom), st, 16'($urandom));
				else if (ph == aprs_pkg::PH_DATA)
					send(aprs_pkg::MODE_STATUS, '0, '0, st, 16'($urandom));
				else
					send(aprs_pkg::MODE_DATA, '0, '0, st, 16'($urandom));
			end else if (ph == aprs_pkg::PH_WAIT_BSY) begin
				st[aprs_pkg::ST_BSY] = (r >= 70);
				send(aprs_pkg::MODE_STATUS, '0, '0, st, '0);
			end else if (ph == aprs_pkg::PH_WAIT_DRQ) begin
				st[aprs_pkg::ST_ERR] = (r < 10);
				st[aprs_pkg::ST_DRQ] = (r < 70);
				send(aprs_pkg::MODE_STATUS, '0, '0, st, '0);
			end else begin
				if (!whole && words == cut)
					return;
				send(aprs_pkg::MODE_DATA, '0, '0, '0, 16'($urandom));
				words++;
			end
		end
	endtask

	task automatic run_phase(bit drive, logic [aprs_pkg::POLL_W-1:0] limit, int idle,
			int stall, int hold, bit pause);
		int mark;
		bit paused;
		drain();
		write_setting(aprs_pkg::CFG_DRIVE_PRESENT, aprs_pkg::POLL_W'(drive));
		write_setting(aprs_pkg::CFG_POLL_LIMIT, limit);
		@(posedge clk);
		idle_pct = idle;
		stall_pct = stall;
		hold_ask = hold;
		mark = useful_items;
		paused = 1'b0;
		while (useful_items - mark < 16) begin
			if (pause && !paused && useful_items - mark >= 8) begin
				drain();
				paused = 1'b1;
			end
			read_session();
		end
	endtask

	function automatic plan_row_t item_row(logic [1:0] m, logic [aprs_pkg::LBA_W-1:0] lba,
			logic [aprs_pkg::COUNT_W-1:0] cnt, logic [7:0] st,
			logic [aprs_pkg::WORD_W-1:0] w, bit typed = 1'b0,
			aprs_pkg::rkind_t want = aprs_pkg::RK_DONE_OK);
		return '{is_cfg: 1'b0, cfg_id: aprs_pkg::CFG_DRIVE_PRESENT, cfg_val: '0, m: m,
			lba: lba, cnt: cnt, st: st, w: w, typed: typed, want: want};
	endfunction

	function automatic plan_row_t cfg_row(aprs_pkg::cfg_reg_t id,
			logic [aprs_pkg::POLL_W-1:0] val);
		return '{is_cfg: 1'b1, cfg_id: id, cfg_val: val, m: aprs_pkg::MODE_START, lba: '0,
			cnt: '0, st: '0, w: '0, typed: 1'b0, want: aprs_pkg::RK_DONE_OK};
	endfunction

	// receiver side: random stall, or a long hold when asked
	always @(negedge clk) begin
		if (hold_ask != 0) begin
			hold_left = hold_ask;
			hold_ask = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	task automatic flag(string field, logic [aprs_pkg::IDX_W-1:0] want,
			logic [aprs_pkg::IDX_W-1:0] got);
		faults++;
		$display("%0t: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
	endtask

	always @(posedge clk) begin : rsp_check
		aprs_pkg::rsp_t want_beat;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (host_ops_due.size() == 0) begin
				faults++;
				$display("%0t: result beat with nothing due, kind 0x%0h", $time, kind);
			end else begin
				want_beat = host_ops_due.pop_front();
				if (kind !== want_beat.kind)
					flag("kind", want_beat.kind, kind);
				if (reg_select !== want_beat.sel)
					flag("reg_select", want_beat.sel, reg_select);
				if (reg_value !== want_beat.value)
					flag("reg_value", want_beat.value, reg_value);
				if (buffer_index !== want_beat.idx)
					flag("buffer_index", want_beat.idx, buffer_index);
				if (data_out !== want_beat.data)
					flag("data_out", want_beat.data, data_out);
				if (last !== want_beat.last)
					flag("last", want_beat.last, last);
			end
		end
	end

	initial begin : stimulus
		plan_row_t script[$];
		// no drive after reset, then zero count, stray beats and a full setup
		script.push_back(item_row(aprs_pkg::MODE_START, 28'h123_4567, 29'd5, '0, '0, 1'b1,
			aprs_pkg::RK_DONE_ERR));
		script.push_back(cfg_row(aprs_pkg::CFG_DRIVE_PRESENT, 17'd1));
		script.push_back(cfg_row(aprs_pkg::CFG_POLL_LIMIT, 17'd3));
		script.push_back(item_row(aprs_pkg::MODE_START, 28'hABC_DEF0, '0, '0, '0, 1'b1,
			aprs_pkg::RK_DONE_OK));
		script.push_back(item_row(aprs_pkg::MODE_STATUS, '0, '0, 8'h00, '0));
		script.push_back(item_row(aprs_pkg::MODE_DATA, '0, '0, '0, 16'hFFFF));
		script.push_back(item_row(MODE_UNUSED, '1, '1, 8'hFF, 16'hFFFF));
		script.push_back(item_row(aprs_pkg::MODE_START, '1, 29'd2, '0, '0, 1'b1,
			aprs_pkg::RK_STATUS_REQ));
		script.push_back(item_row(aprs_pkg::MODE_STATUS, '0, '0, 8'h80, '0));
		script.push_back(item_row(aprs_pkg::MODE_STATUS, '0, '0, 8'h7F, '0));
		script.push_back(item_row(aprs_pkg::MODE_DATA, '0, '0, '0, 16'h1234));
		script.push_back(item_row(aprs_pkg::MODE_STATUS, '0, '0, 8'h00, '0));
		// err together with drq and bsy
		script.push_back(item_row(aprs_pkg::MODE_STATUS, '0, '0, 8'hFF, '0, 1'b1,
			aprs_pkg::RK_DONE_ERR));
		// busy wait runs out of polls
		script.push_back(item_row(aprs_pkg::MODE_START, '0, '1, '0, '0, 1'b1,
			aprs_pkg::RK_STATUS_REQ));
		script.push_back(item_row(aprs_pkg::MODE_STATUS, '0, '0, 8'hFF, '0));
		script.push_back(item_row(aprs_pkg::MODE_STATUS, '0, '0, 8'h80, '0));
		script.push_back(item_row(aprs_pkg::MODE_STATUS, '0, '0, 8'h80, '0, 1'b1,
			aprs_pkg::RK_DONE_ERR));
		// count above 2^28, batch capped
		script.push_back(item_row(aprs_pkg::MODE_START, 28'hFFF_FFFE, 29'h1000_0001, '0, '0,
			1'b1, aprs_pkg::RK_STATUS_REQ));
		script.push_back(item_row(aprs_pkg::MODE_STATUS, '0, '0, 8'h00, '0));
		script.push_back(item_row(aprs_pkg::MODE_STATUS, '0, '0, 8'h88, '0, 1'b1,
			aprs_pkg::RK_BURST_REQ));
		script.push_back(item_row(aprs_pkg::MODE_DATA, '0, '0, '0, 16'hFFFF));
		script.push_back(item_row(aprs_pkg::MODE_DATA, '0, '0, '0, 16'h0000));
		// new start drops the burst in flight
		script.push_back(item_row(aprs_pkg::MODE_START, '1, '0, '0, '0, 1'b1,
			aprs_pkg::RK_DONE_OK));
		// a zero poll limit behaves like one
		script.push_back(cfg_row(aprs_pkg::CFG_POLL_LIMIT, 17'd0));
		script.push_back(item_row(aprs_pkg::MODE_START, 28'd5, 29'd1, '0, '0, 1'b1,
			aprs_pkg::RK_STATUS_REQ));
		script.push_back(item_row(aprs_pkg::MODE_STATUS, '0, '0, 8'h80, '0, 1'b1,
			aprs_pkg::RK_DONE_ERR));

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (script[i]) begin
			if (script[i].is_cfg) begin
				drain();
				write_setting(script[i].cfg_id, script[i].cfg_val);
			end else begin
				send(script[i].m, script[i].lba, script[i].cnt, script[i].st, script[i].w,
					script[i].typed, script[i].want);
			end
		end

		// long hold on the result side fills the job queue first
		run_phase(1'b1, 17'd131071, 0, 0, 300, 1'b0);
		run_phase(1'b1, 17'd4, 71, 0, 0, 1'b0);
		run_phase(1'b1, 17'd1, 0, 71, 0, 1'b0);
		run_phase(1'b0, 17'd100000, 32, 32, 0, 1'b0);
		run_phase(1'b1, 17'd2, 32, 32, 0, 1'b1);
		run_phase(1'b1, 17'd100000, 0, 0, 0, 1'b0);

		drain();
		if (faults == 0)
			$display("ata_pio_read_sequencer test passed");
		else
			$display("ata_pio_read_sequencer test failed");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+sv
sv/aprs_pkg.sv
sv/aprs_queue.sv
sv/aprs_front.sv
sv/aprs_back.sv
sv/ata_pio_read_sequencer.sv
sv/aprs_checker.sv
tb/ata_pio_read_sequencer_test.sv
